@@ hdl/utf8l_pkg.sv @@
// Shared types, codes and byte helpers for the lenient UTF-8 decoder.
// No dependencies; compile first.
package utf8l_pkg;

    typedef logic [20:0] cp_t;
    typedef logic [7:0]  byte_t;

    // Sequence length codes returned by lead_len
    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_ASCII   = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    localparam cp_t REPLACEMENT = 21'h00FFFD;

    // Up to three code points caused by one request, oldest in cp[0]
    typedef struct packed {
        logic [1:0]    num;
        cp_t [2:0]     cp;
    } dec_res_t;

    // Open-sequence status, for checking
    typedef struct packed {
        logic [2:0] seq_len;
        logic [1:0] cnt;
    } dec_stat_t;

    function automatic logic [2:0] lead_len(input byte_t c);
        logic [2:0] len;
        if (c[7] == 1'b0)
            len = LEN_ASCII;
        else if (c[7:5] == 3'b110)
            len = LEN_TWO;
        else if (c[7:4] == 4'b1110)
            len = LEN_THREE;
        else if (c[7:3] == 5'b11110)
            len = LEN_FOUR;
        else
            len = LEN_INVALID;
        return len;
    endfunction

    // A lone byte at end of text: ASCII passes, anything else is replaced
    function automatic cp_t single_cp(input byte_t c);
        cp_t v;
        if (c[7] == 1'b0)
            v = {13'b0, c};
        else
            v = REPLACEMENT;
        return v;
    endfunction

endpackage

@@ hdl/utf8l_byte_if.sv @@
// Byte request channel: valid/ready plus raw byte and end-of-text flag.
// Depends on utf8l_pkg.
interface utf8l_byte_if;
    import utf8l_pkg::*;

    logic  valid;
    logic  ready;
    byte_t byte_req;
    logic  final_byte;

    modport source (output valid, output byte_req, output final_byte, input ready);
    modport sink   (input valid, input byte_req, input final_byte, output ready);
endinterface

@@ hdl/utf8l_cp_if.sv @@
// Code point channel: valid/ready plus decoded value and last-of-run flag.
// Depends on utf8l_pkg.
interface utf8l_cp_if;
    import utf8l_pkg::*;

    logic valid;
    logic ready;
    cp_t  code_point;
    logic run_end;

    modport source (output valid, output code_point, output run_end, input ready);
    modport sink   (input valid, input code_point, input run_end, output ready);
endinterface

@@ hdl/utf8l_core.sv @@
// Sequence state and single-pass decode of one byte against the open sequence.
// Depends on utf8l_pkg.
module utf8l_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  utf8l_pkg::byte_t     byte_req,
    input  logic                 final_byte,
    output utf8l_pkg::dec_res_t  res,
    output utf8l_pkg::dec_stat_t stat
);
    import utf8l_pkg::*;

    logic [2:0] seq_len_reg, seq_len_next;
    logic [1:0] cnt_reg, cnt_next;
    byte_t      pend_reg [3];
    logic       wr_en;
    logic [1:0] wr_idx;
    logic [2:0] n_bytes;
    byte_t      x_byte;

    always_comb
    begin
        res          = '0;
        seq_len_next = seq_len_reg;
        cnt_next     = cnt_reg;
        wr_en        = 1'b0;
        wr_idx       = cnt_reg;
        n_bytes      = {1'b0, cnt_reg} + 3'd1;
        x_byte       = (cnt_reg == 2'd2) ? pend_reg[1] : byte_req;

        if (seq_len_reg == LEN_INVALID)
        begin
            if (final_byte)
            begin
                res.num   = 2'd1;
                res.cp[0] = single_cp(byte_req);
            end
            else
            begin
                unique case (lead_len(byte_req))
                    LEN_ASCII:
                    begin
                        res.num   = 2'd1;
                        res.cp[0] = {13'b0, byte_req};
                    end
                    LEN_INVALID:
                    begin
                        res.num   = 2'd1;
                        res.cp[0] = REPLACEMENT;
                    end
                    default:
                    begin
                        wr_en        = 1'b1;
                        wr_idx       = 2'd0;
                        cnt_next     = 2'd1;
                        seq_len_next = lead_len(byte_req);
                    end
                endcase
            end
        end
        else if (n_bytes == seq_len_reg)
        begin
            // sequence complete
            res.num = 2'd1;
            unique case (seq_len_reg)
                LEN_TWO:   res.cp[0] = {10'b0, pend_reg[0][4:0], byte_req[5:0]};
                LEN_THREE: res.cp[0] = {5'b0, pend_reg[0][3:0], pend_reg[1][5:0],
                                        byte_req[5:0]};
                LEN_FOUR:  res.cp[0] = {pend_reg[0][2:0], pend_reg[1][5:0],
                                        pend_reg[2][5:0], byte_req[5:0]};
                default:   res.cp[0] = REPLACEMENT;
            endcase
            seq_len_next = LEN_INVALID;
            cnt_next     = 2'd0;
        end
        else if (final_byte)
        begin
            // truncated: lead replaced, trailing bytes re-decoded as leads
            res.cp[0] = REPLACEMENT;
            if (cnt_reg == 2'd1)
            begin
                res.num   = 2'd2;
                res.cp[1] = single_cp(byte_req);
            end
            else if (lead_len(x_byte) == LEN_TWO)
            begin
                res.num   = 2'd2;
                res.cp[1] = {10'b0, x_byte[4:0], byte_req[5:0]};
            end
            else
            begin
                res.num   = 2'd3;
                res.cp[1] = single_cp(x_byte);
                res.cp[2] = single_cp(byte_req);
            end
            seq_len_next = LEN_INVALID;
            cnt_next     = 2'd0;
        end
        else
        begin
            wr_en    = 1'b1;
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= LEN_INVALID;
            cnt_reg     <= 2'd0;
        end
        else if (fire)
        begin
            seq_len_reg <= seq_len_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
            pend_reg[wr_idx] <= byte_req;
    end

    assign stat.seq_len = seq_len_reg;
    assign stat.cnt     = cnt_reg;

endmodule

@@ hdl/utf8l_out.sv @@
// Result register: holds up to three code points, one out per cycle while ready.
// Depends on utf8l_pkg and utf8l_cp_if.
module utf8l_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  utf8l_pkg::dec_res_t res,
    output logic                can_load,
    utf8l_cp_if.source          out_chan
);
    import utf8l_pkg::*;

    logic [1:0] num_reg;
    cp_t [2:0]  cp_reg;
    logic       take;

    assign take     = out_chan.valid && out_chan.ready;
    assign can_load = (num_reg == 2'd0) || (num_reg == 2'd1 && out_chan.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_reg <= 2'd0;
        else if (load)
            num_reg <= res.num;
        else if (take)
            num_reg <= num_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cp_reg <= res.cp;
        else if (take)
            cp_reg <= {cp_reg[2], cp_reg[2:1]};
    end

    assign out_chan.valid      = (num_reg != 2'd0);
    assign out_chan.code_point = cp_reg[0];
    assign out_chan.run_end    = (num_reg == 2'd1);

endmodule

@@ hdl/utf8_lenient_decoder.sv @@
// Lenient UTF-8 decoder, top level.
// Depends on utf8l_pkg, utf8l_byte_if, utf8l_cp_if, utf8l_core, utf8l_out.
//
// in_chan : one byte request per handshake (byte_req, final_byte on the last byte).
// out_chan: decoded code points; run_end marks the last result of one request.
//
// ASCII and invalid leads give one result; a lead byte opens a 2..4 byte
// sequence whose trailing bytes are taken unchecked (low six bits). Bytes of
// an open sequence give no result until the sequence completes.
// When final_byte arrives inside a truncated sequence the lead becomes 0xFFFD
// and the buffered and final bytes are decoded again as leads: up to three results.
//
// Latency: first result valid the cycle after the request is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver keeps ready high; the result register empties one code point
// per cycle while the receiver is ready, so a truncated-text flush holds
// in_chan.ready low until its last result is leaving.
// Receiver stall: the result register holds; in_chan.ready falls once the
// held request's last result cannot leave in the same cycle.
// Reset: clears the open sequence and empties the result register.
module utf8_lenient_decoder (
    input logic         clk,
    input logic         rst_n,
    utf8l_byte_if.sink  in_chan,
    utf8l_cp_if.source  out_chan
);
    import utf8l_pkg::*;

    logic      in_fire;
    logic      can_load;
    dec_res_t  res;
    dec_stat_t stat;

    assign in_chan.ready = can_load;
    assign in_fire       = in_chan.valid && can_load;

    utf8l_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .byte_req   (in_chan.byte_req),
        .final_byte (in_chan.final_byte),
        .res        (res),
        .stat       (stat)
    );

    // load only when the request produced results; zero-result bytes just update state
    utf8l_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire && (res.num != 2'd0)),
        .res      (res),
        .can_load (can_load),
        .out_chan (out_chan)
    );

    // a request is never taken over results that are not leaving
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!out_chan.valid || (out_chan.ready && out_chan.run_end)))
        else $error("request accepted over pending results");

    // end of text always leaves no open sequence
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_chan.final_byte) |=> (stat.seq_len == LEN_INVALID))
        else $error("sequence still open after final byte");

    // an open sequence always holds at least its lead and is not yet full
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.seq_len != LEN_INVALID) |->
            (stat.cnt != 2'd0 && {1'b0, stat.cnt} < stat.seq_len))
        else $error("pending count out of range");

endmodule
